>>> sv/olpos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package olpos_pkg;

    localparam int CAPACITY_DEFAULT   = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int REQ_TYPE_W = 3;
    localparam int POSITION_W = 7;
    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 7;

    localparam logic [REQ_TYPE_W-1:0] OP_ADD_FRONT = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] OP_ADD_BACK  = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] OP_ADD_AT    = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] OP_REM_FRONT = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] OP_REM_BACK  = 3'd4;
    localparam logic [REQ_TYPE_W-1:0] OP_REM_AT    = 3'd5;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SH_RD,
        S_SH_WR,
        S_WR_NEW,
        S_RM_RD,
        S_RM_CAP,
        S_RM_CHECK,
        S_RS_RD,
        S_RS_WR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [POSITION_W-1:0] position;
        logic [WORD_W-1:0]     item_value;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]  removed_value;
        status_t            status;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic latch;
        logic rd_back;
        logic rd_fwd;
        logic rd_here;
        logic wr_shift;
        logic wr_new;
        logic idx_dec;
        logic idx_inc;
        logic capture;
        logic fill_inc;
        logic fill_dec;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  idx_at_target;
        logic  more_shift;
        logic  out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/olpos_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module olpos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/olpos_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module olpos_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire olpos_pkg::dp_stat_t stat,
    output olpos_pkg::dp_cmd_t      cmd
);

    olpos_pkg::state_t state_reg;
    olpos_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= olpos_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            olpos_pkg::S_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.latch  = 1'b1;
                    state_next = olpos_pkg::S_DISPATCH;
                end
            end
            olpos_pkg::S_DISPATCH: begin
                unique case (stat.kind)
                    olpos_pkg::KIND_INSERT: begin
                        if (stat.idx_at_target) begin
                            state_next = olpos_pkg::S_WR_NEW;
                        end else begin
                            state_next = olpos_pkg::S_SH_RD;
                        end
                    end
                    olpos_pkg::KIND_REMOVE: state_next = olpos_pkg::S_RM_RD;
                    default:                state_next = olpos_pkg::S_RESP;
                endcase
            end
            olpos_pkg::S_SH_RD: begin
                cmd.rd_back = 1'b1;
                state_next  = olpos_pkg::S_SH_WR;
            end
            olpos_pkg::S_SH_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.idx_dec  = 1'b1;
                state_next   = olpos_pkg::S_DISPATCH;
            end
            olpos_pkg::S_WR_NEW: begin
                cmd.wr_new   = 1'b1;
                cmd.fill_inc = 1'b1;
                state_next   = olpos_pkg::S_RESP;
            end
            olpos_pkg::S_RM_RD: begin
                cmd.rd_here = 1'b1;
                state_next  = olpos_pkg::S_RM_CAP;
            end
            olpos_pkg::S_RM_CAP: begin
                cmd.capture = 1'b1;
                state_next  = olpos_pkg::S_RM_CHECK;
            end
            olpos_pkg::S_RM_CHECK: begin
                if (stat.more_shift) begin
                    state_next = olpos_pkg::S_RS_RD;
                end else begin
                    cmd.fill_dec = 1'b1;
                    state_next   = olpos_pkg::S_RESP;
                end
            end
            olpos_pkg::S_RS_RD: begin
                cmd.rd_fwd = 1'b1;
                state_next = olpos_pkg::S_RS_WR;
            end
            olpos_pkg::S_RS_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = olpos_pkg::S_RM_CHECK;
            end
            olpos_pkg::S_RESP: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = olpos_pkg::S_IDLE;
                end
            end
            default: state_next = olpos_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/olpos_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module olpos_dp #(
    parameter int CAPACITY   = olpos_pkg::CAPACITY_DEFAULT,
    parameter int DATA_WIDTH = olpos_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire olpos_pkg::req_t    s_data,
    input  wire olpos_pkg::dp_cmd_t cmd,
    output olpos_pkg::dp_stat_t     stat,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output olpos_pkg::rsp_t         m_data
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > olpos_pkg::POSITION_W) ? CW : olpos_pkg::POSITION_W;
    localparam int KW   = (DATA_WIDTH < olpos_pkg::WORD_W) ? DATA_WIDTH : olpos_pkg::WORD_W;

    logic [CW-1:0]         fill_reg;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         tgt_reg;
    olpos_pkg::kind_t      kind_reg;
    olpos_pkg::status_t    status_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] removed_reg;
    logic                  m_valid_reg;
    olpos_pkg::rsp_t       m_data_reg;

    logic [CMPW-1:0]         fill_ext;
    logic [CMPW-1:0]         pos_ext;
    logic [CMPW-1:0]         ins_tgt;
    logic [CMPW-1:0]         dec_tgt;
    logic [CMPW-1:0]         dec_idx;
    logic                    is_ins;
    olpos_pkg::kind_t        dec_kind;
    olpos_pkg::status_t      dec_status;
    logic [DATA_WIDTH-1:0]   in_word;
    logic [olpos_pkg::WORD_W-1:0] out_word;

    logic                  ram_wr_en;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [IW-1:0]         ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    always_comb begin
        fill_ext   = CMPW'(fill_reg);
        pos_ext    = CMPW'(s_data.position);
        is_ins     = 1'b0;
        ins_tgt    = '0;
        dec_kind   = olpos_pkg::KIND_NONE;
        dec_status = olpos_pkg::STAT_OK;
        dec_tgt    = '0;
        unique case (s_data.req_type)
            olpos_pkg::OP_ADD_FRONT: begin
                is_ins  = 1'b1;
                ins_tgt = '0;
            end
            olpos_pkg::OP_ADD_BACK: begin
                is_ins  = 1'b1;
                ins_tgt = fill_ext;
            end
            olpos_pkg::OP_ADD_AT: begin
                is_ins  = 1'b1;
                ins_tgt = pos_ext;
            end
            olpos_pkg::OP_REM_FRONT: begin
                if (fill_reg == '0) begin
                    dec_status = olpos_pkg::STAT_EMPTY;
                end else begin
                    dec_kind = olpos_pkg::KIND_REMOVE;
                    dec_tgt  = '0;
                end
            end
            olpos_pkg::OP_REM_BACK: begin
                if (fill_reg == '0) begin
                    dec_status = olpos_pkg::STAT_EMPTY;
                end else begin
                    dec_kind = olpos_pkg::KIND_REMOVE;
                    dec_tgt  = fill_ext - CMPW'(1);
                end
            end
            olpos_pkg::OP_REM_AT: begin
                if (pos_ext >= fill_ext) begin
                    dec_status = olpos_pkg::STAT_RANGE;
                end else begin
                    dec_kind = olpos_pkg::KIND_REMOVE;
                    dec_tgt  = pos_ext;
                end
            end
            default: begin
            end
        endcase
        if (is_ins) begin
            if (ins_tgt > fill_ext) begin
                dec_status = olpos_pkg::STAT_RANGE;
            end else if (fill_ext == CMPW'(CAPACITY)) begin
                dec_status = olpos_pkg::STAT_FULL;
            end else begin
                dec_kind = olpos_pkg::KIND_INSERT;
                dec_tgt  = ins_tgt;
            end
        end
        dec_idx = (dec_kind == olpos_pkg::KIND_INSERT) ? fill_ext : dec_tgt;
    end

    always_comb begin
        in_word           = '0;
        in_word[KW-1:0]   = s_data.item_value[KW-1:0];
        out_word          = '0;
        out_word[KW-1:0]  = removed_reg[KW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
            kind_reg    <= olpos_pkg::KIND_NONE;
        end else begin
            if (cmd.fill_inc) begin
                fill_reg <= fill_reg + CW'(1);
            end else if (cmd.fill_dec) begin
                fill_reg <= fill_reg - CW'(1);
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.latch) begin
                kind_reg <= dec_kind;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            status_reg  <= dec_status;
            tgt_reg     <= dec_tgt[IW-1:0];
            idx_reg     <= dec_idx[IW-1:0];
            word_reg    <= in_word;
            removed_reg <= '0;
        end else begin
            if (cmd.idx_dec) begin
                idx_reg <= idx_reg - IW'(1);
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (cmd.capture) begin
                removed_reg <= ram_rd_data;
            end
        end
        if (cmd.load_out) begin
            m_data_reg.removed_value <= out_word;
            m_data_reg.status        <= status_reg;
            m_data_reg.entry_count   <= olpos_pkg::COUNT_W'(fill_reg);
        end
    end

    always_comb begin
        ram_wr_en   = cmd.wr_shift | cmd.wr_new;
        ram_wr_data = cmd.wr_new ? word_reg : ram_rd_data;
        ram_rd_en   = cmd.rd_back | cmd.rd_fwd | cmd.rd_here;
        priority if (cmd.rd_back) begin
            ram_rd_addr = idx_reg - IW'(1);
        end else if (cmd.rd_fwd) begin
            ram_rd_addr = idx_reg + IW'(1);
        end else begin
            ram_rd_addr = idx_reg;
        end
    end

    olpos_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        stat.kind          = kind_reg;
        stat.idx_at_target = (idx_reg == tgt_reg);
        stat.more_shift    = ((CW'(idx_reg) + CW'(1)) < fill_reg);
        stat.out_free      = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> sv/ordered_list_with_positional_ops_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY words with front, back and positional insert and remove.
// Each request word on the s_ channel yields exactly one result word on the m_ channel,
// carrying the removed word, a status code and the entry count after the request.
// Requests are handled one at a time; entries are moved through a single-port-pair RAM,
// one read and one write per moved entry, so the cost grows with the entries shifted.
// States from acceptance to the result register, with k entries moved:
//   rejected request or unused code: dispatch, then the result state;
//   insert: dispatch, k read-write pairs each back to dispatch, new-word write, result;
//   remove: dispatch, read, capture, check, k read-write pairs each back to check, result.
// Worst case is an insert or remove at the front, which moves the most entries.
// The result sits in an output register, so a new request is taken while it waits.
// If the receiver stalls with a result still held, the next result waits in the
// controller until the register frees, and no further request is taken meanwhile.
// Reset empties the list at once; stored words are not cleared and need no sweep.

module ordered_list_with_positional_ops_core #(
    parameter int CAPACITY   = olpos_pkg::CAPACITY_DEFAULT,
    parameter int DATA_WIDTH = olpos_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire olpos_pkg::req_t s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output olpos_pkg::rsp_t      m_data
);

    olpos_pkg::dp_cmd_t  cmd;
    olpos_pkg::dp_stat_t stat;

    olpos_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    olpos_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in progress");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("pending result overwritten");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == olpos_pkg::STAT_FULL)
            |-> (m_data.entry_count == olpos_pkg::COUNT_W'(CAPACITY)))
        else $error("full status with wrong entry count");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == olpos_pkg::STAT_EMPTY)
            |-> (m_data.entry_count == '0))
        else $error("empty status with nonzero entry count");

endmodule

`default_nettype wire
